FILE: design/arx_model_step_assert.svh
// assertion macros used by the checker file
`ifndef ARX_MODEL_STEP_ASSERT_SVH
`define ARX_MODEL_STEP_ASSERT_SVH

// generic check with a fixed message
`define ARX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("arx_model_step: assertion failed");

// check with a caller message
`define ARX_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: design/arx_pkg.sv
package arx_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int NUM_COEFS  = 4;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DELAY_W    = 5;

  localparam int FEEDBACK_ORDER_DEF    = 4;
  localparam int FEEDFORWARD_ORDER_DEF = 4;
  localparam int MAX_DELAY_DEF         = 16;

  localparam logic signed [SAMPLE_W-1:0] SMAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 16'sh8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IN_DELAY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEFS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEFS   = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_min;
    logic signed [SAMPLE_W-1:0] in_max;
    logic signed [SAMPLE_W-1:0] out_min;
    logic signed [SAMPLE_W-1:0] out_max;
    logic                       clamp_in;
    logic                       clamp_out;
    logic [DELAY_W-1:0]         delay;
    logic [CFG_DATA_W-1:0]      fb_coefs;
    logic [CFG_DATA_W-1:0]      ff_coefs;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
  } mac_ctl_t;

endpackage

FILE: design/arx_cfg_regs.sv
module arx_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output arx_pkg::cfg_t                  cfg_o
);
  import arx_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic signed [SAMPLE_W-1:0] wval;

  assign wval = signed'(cfg_wdata_i[SAMPLE_W-1:0]);

  // a limit written past its partner drags the partner along
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_MIN: begin
          cfg_d.in_min = wval;
          if (wval > cfg_q.in_max) cfg_d.in_max = wval;
        end
        REG_INPUT_MAX: begin
          cfg_d.in_max = wval;
          if (cfg_q.in_min > wval) cfg_d.in_min = wval;
        end
        REG_OUTPUT_MIN: begin
          cfg_d.out_min = wval;
          if (wval > cfg_q.out_max) cfg_d.out_max = wval;
        end
        REG_OUTPUT_MAX: begin
          cfg_d.out_max = wval;
          if (cfg_q.out_min > wval) cfg_d.out_min = wval;
        end
        REG_CLAMP_EN: begin
          cfg_d.clamp_in  = cfg_wdata_i[0];
          cfg_d.clamp_out = cfg_wdata_i[1];
        end
        REG_IN_DELAY: cfg_d.delay    = cfg_wdata_i[DELAY_W-1:0];
        REG_FB_COEFS: cfg_d.fb_coefs = cfg_wdata_i;
        REG_FF_COEFS: cfg_d.ff_coefs = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_min    <= SMIN;
      cfg_q.in_max    <= SMAX;
      cfg_q.out_min   <= SMIN;
      cfg_q.out_max   <= SMAX;
      cfg_q.clamp_in  <= 1'b0;
      cfg_q.clamp_out <= 1'b0;
      cfg_q.delay     <= DELAY_W'(1);
      cfg_q.fb_coefs  <= '0;
      cfg_q.ff_coefs  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/arx_mac.sv
module arx_mac #(
  parameter int ACC_W = 35
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arx_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [arx_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [arx_pkg::SAMPLE_W-1:0] data_i,
  output logic signed [ACC_W-1:0]             acc_o
);
  import arx_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_W;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     en_q, sub_q;

  assign prod_d = coef_i * data_i;

  // product registered first, accumulated in the next cycle
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (en_q) begin
      if (sub_q) acc_d = acc_q - ACC_W'(prod_q);
      else       acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      sub_q <= 1'b0;
      acc_q <= '0;
    end else begin
      en_q  <= ctl_i.en;
      sub_q <= ctl_i.sub;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: design/arx_model_step.sv
// channel  | signals                                  | moves
// ---------+------------------------------------------+-------------------------------
// in       | in_valid_i, in_ready_o, control_sample_i | one plant input sample
// out      | out_valid_o, out_ready_i, plant_output_o | modelled output and sat flag
// cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i         | register write, no wait
//
// an item is worked by the one multiply-accumulate unit, which walks every tap in turn,
// then drains and writes the result register before the result is valid
// in_ready_o is high only while the sequencer is idle
// the result register is separate, so an unread result does not block the next sample
// a finished sum waits for that register while the previous result is still held
// reset clears both histories to zero and loads the register defaults
module arx_model_step #(
  parameter int FEEDBACK_ORDER    = arx_pkg::FEEDBACK_ORDER_DEF,
  parameter int FEEDFORWARD_ORDER = arx_pkg::FEEDFORWARD_ORDER_DEF,
  parameter int MAX_DELAY         = arx_pkg::MAX_DELAY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [arx_pkg::SAMPLE_W-1:0] control_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [arx_pkg::SAMPLE_W-1:0] plant_output_o,
  output logic                                output_saturated_o,
  input  logic                                cfg_we_i,
  input  logic [arx_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [arx_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import arx_pkg::*;

  localparam int HIST_D  = MAX_DELAY + FEEDFORWARD_ORDER;
  localparam int HIST_IW = $clog2(HIST_D);
  localparam int OH_IW   = (FEEDBACK_ORDER > 1) ? $clog2(FEEDBACK_ORDER) : 1;
  localparam int N_TAPS  = FEEDFORWARD_ORDER + FEEDBACK_ORDER;
  localparam int TAP_W   = $clog2(N_TAPS);
  localparam int ACC_W   = COEF_W + SAMPLE_W + $clog2(N_TAPS) + 1;
  localparam int Y_W     = ACC_W - FRAC_BITS;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  function automatic logic signed [COEF_W-1:0] coef_pick(input logic [CFG_DATA_W-1:0] pk,
                                                        input int unsigned i);
    if (i >= NUM_COEFS) return '0;
    return pk[COEF_W*i +: COEF_W];
  endfunction

  cfg_t cfg;

  logic [1:0]       state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             in_fire, done_fire;
  mac_ctl_t         mac_ctl;

  logic signed [SAMPLE_W-1:0] in_hist_q [HIST_D];
  logic signed [SAMPLE_W-1:0] out_hist_q [FEEDBACK_ORDER];
  logic signed [SAMPLE_W-1:0] u_clamped;

  logic [HIST_IW-1:0]         dly_eff;
  logic [HIST_IW-1:0]         ff_idx;
  logic [TAP_W-1:0]           fb_k;
  logic                       is_fb;
  logic signed [COEF_W-1:0]   mac_coef;
  logic signed [SAMPLE_W-1:0] mac_data;
  logic signed [ACC_W-1:0]    mac_acc;

  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [Y_W-1:0]      y_full;
  logic signed [SAMPLE_W-1:0] y_res;
  logic                       y_sat;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] plant_output_q;
  logic                       sat_q;

  arx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    u_clamped = control_sample_i;
    if (cfg.clamp_in) begin
      if (control_sample_i > cfg.in_max)      u_clamped = cfg.in_max;
      else if (control_sample_i < cfg.in_min) u_clamped = cfg.in_min;
    end
  end

  // delay of zero acts as one, anything above MAX_DELAY as MAX_DELAY
  always_comb begin
    if (cfg.delay == '0) begin
      dly_eff = HIST_IW'(1);
    end else if (32'(cfg.delay) > 32'(MAX_DELAY)) begin
      dly_eff = HIST_IW'(MAX_DELAY);
    end else begin
      dly_eff = HIST_IW'(cfg.delay);
    end
  end

  // feedforward taps first, then feedback taps subtracted
  assign is_fb  = (tap_q >= TAP_W'(FEEDFORWARD_ORDER));
  assign ff_idx = dly_eff + HIST_IW'(tap_q);
  assign fb_k   = tap_q - TAP_W'(FEEDFORWARD_ORDER);

  always_comb begin
    if (is_fb) begin
      mac_coef = coef_pick(cfg.fb_coefs, 32'(fb_k));
      mac_data = out_hist_q[fb_k[OH_IW-1:0]];
    end else begin
      mac_coef = coef_pick(cfg.ff_coefs, 32'(tap_q));
      mac_data = in_hist_q[ff_idx];
    end
  end

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    mac_ctl   = '0;
    done_fire = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d     = S_RUN;
          tap_d       = '0;
          mac_ctl.clr = 1'b1;
        end
      end
      S_RUN: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.sub = is_fb;
        if (tap_q == TAP_W'(N_TAPS - 1)) state_d = S_DRAIN;
        else                             tap_d   = tap_q + TAP_W'(1);
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          done_fire = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  arx_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .acc_o  (mac_acc)
  );

  // round half up, dropping the Q2.14 coefficient fraction to the sample format, then clamp or saturate
  assign acc_rnd = mac_acc + ACC_W'(ROUND_HALF);
  assign y_full  = Y_W'(acc_rnd >>> FRAC_BITS);

  always_comb begin
    y_res = SAMPLE_W'(y_full);
    y_sat = 1'b0;
    if (cfg.clamp_out) begin
      if (y_full > Y_W'(cfg.out_max))      y_res = cfg.out_max;
      else if (y_full < Y_W'(cfg.out_min)) y_res = cfg.out_min;
    end else if (y_full > Y_W'(SMAX)) begin
      y_res = SMAX;
      y_sat = 1'b1;
    end else if (y_full < Y_W'(SMIN)) begin
      y_res = SMIN;
      y_sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HIST_D; i++) in_hist_q[i] <= '0;
      for (int i = 0; i < FEEDBACK_ORDER; i++) out_hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      if (done_fire)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_fire) begin
        for (int i = HIST_D - 1; i > 0; i--) in_hist_q[i] <= in_hist_q[i-1];
        in_hist_q[0] <= u_clamped;
      end
      if (done_fire) begin
        for (int i = FEEDBACK_ORDER - 1; i > 0; i--) out_hist_q[i] <= out_hist_q[i-1];
        out_hist_q[0] <= y_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      plant_output_q <= y_res;
      sat_q          <= y_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign plant_output_o     = plant_output_q;
  assign output_saturated_o = sat_q;

endmodule

FILE: design/arx_model_step_chk.sv
`include "arx_model_step_assert.svh"

module arx_model_step_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [arx_pkg::SAMPLE_W-1:0] control_sample_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [arx_pkg::SAMPLE_W-1:0] plant_output_o,
  input logic                                output_saturated_o
);

  // a held result stays put until its transfer
  `ARX_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(plant_output_o) && $stable(output_saturated_o))

  // one sample at a time: busy right after a transfer in
  `ARX_ASSERT_MSG(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "arx_model_step: ready after input transfer")

  // no result can appear in the cycle after a sample enters
  `ARX_ASSERT(a_no_early_out, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o))

  // saturation flag only with a rail value
  `ARX_ASSERT_MSG(a_sat_rail, clk_i, rst_ni, out_valid_o && output_saturated_o |-> plant_output_o == arx_pkg::SMAX || plant_output_o == arx_pkg::SMIN, "arx_model_step: saturated output off rail")

endmodule

bind arx_model_step arx_model_step_chk u_arx_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .control_sample_i   (control_sample_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .plant_output_o     (plant_output_o),
  .output_saturated_o (output_saturated_o)
);
